// ===== hw/rtl/murmur64a_byte_hash_core_macros.svh =====
// assertion macros shared by the murmur64a byte hash rtl
// each macro expands to a concurrent assertion on aclk, or to nothing in synthesis
`ifndef MURMUR64A_BYTE_HASH_CORE_MACROS_SVH
`define MURMUR64A_BYTE_HASH_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, quiet while in reset
`define MMH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, quiet while in reset
`define MMH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MMH_ASSERT_NOW(label, ante, cons, msg)
`define MMH_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/mmh_pkg.sv =====
// shared constants, types and sequencer states of the murmur64a byte hash
// no dependencies
package mmh_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned HALF_W   = 32;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned LENGTH_W = 32;
    localparam int unsigned BYTES    = 8;

    localparam logic [WORD_W-1:0] MIX_MUL   = 64'hc6a4_a793_5bd1_e995;
    localparam logic [WORD_W-1:0] HASH_SEED = 64'h0000_0000_e17a_1465;
    localparam int unsigned       MIX_SHIFT = 47;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEED,
        ST_MIX1,
        ST_MIX2,
        ST_FOLD,
        ST_FINISH
    } mmh_state_t;

    // partial product steps of the multiply unit
    typedef enum logic [1:0] {
        MS_LO_LO,
        MS_HI_LO,
        MS_LO_HI
    } mmh_mul_step_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] operand;
    } mmh_mul_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] product;
    } mmh_mul_rsp_t;

    // xor-shift used after the first multiply and on the final hash
    function automatic logic [WORD_W-1:0] xor_shift(input logic [WORD_W-1:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

endpackage

// ===== hw/rtl/mmh_mul.sv =====
// iterative multiply by the mix constant, modulo 2^64, on one 32x32 multiplier
// depends on mmh_pkg and the assertion macro header
`include "murmur64a_byte_hash_core_macros.svh"

module mmh_mul
    import mmh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  mmh_mul_req_t req,
    output mmh_mul_rsp_t rsp
);

    logic                busy_reg;
    logic                done_reg;
    mmh_mul_step_t       step_reg;
    logic [WORD_W-1:0]   operand_reg;
    logic [WORD_W-1:0]   acc_reg;

    logic [HALF_W-1:0]   op_x;
    logic [HALF_W-1:0]   op_y;
    logic [WORD_W-1:0]   mul_p;

    // operand selection per partial product
    always_comb begin
        unique case (step_reg)
            MS_LO_LO: begin
                op_x = operand_reg[HALF_W-1:0];
                op_y = MIX_MUL[HALF_W-1:0];
            end
            MS_HI_LO: begin
                op_x = operand_reg[WORD_W-1:HALF_W];
                op_y = MIX_MUL[HALF_W-1:0];
            end
            MS_LO_HI: begin
                op_x = operand_reg[HALF_W-1:0];
                op_y = MIX_MUL[WORD_W-1:HALF_W];
            end
            default: begin
                op_x = '0;
                op_y = '0;
            end
        endcase
    end

    assign mul_p = op_x * op_y;

    // control: three steps after start, then a one-cycle done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= MS_LO_LO;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg) begin
                if (req.start) begin
                    busy_reg <= 1'b1;
                    step_reg <= MS_LO_LO;
                end
            end else begin
                unique case (step_reg)
                    MS_LO_LO: step_reg <= MS_HI_LO;
                    MS_HI_LO: step_reg <= MS_LO_HI;
                    MS_LO_HI: begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                        step_reg <= MS_LO_LO;
                    end
                    default:  step_reg <= MS_LO_LO;
                endcase
            end
        end
    end

    // datapath: low product, then cross terms into the upper half
    always_ff @(posedge aclk) begin
        if (!busy_reg && req.start) begin
            operand_reg <= req.operand;
        end
        if (busy_reg) begin
            if (step_reg == MS_LO_LO) begin
                acc_reg <= mul_p;
            end else begin
                acc_reg[WORD_W-1:HALF_W] <= acc_reg[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0];
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

    `MMH_ASSERT_NOW(a_start_idle, req.start, !busy_reg, "multiply started while busy")
    `MMH_ASSERT_NEXT(a_start_busy, req.start && !busy_reg, busy_reg, "start not taken")
    `MMH_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "done longer than one cycle")

endmodule

// ===== hw/rtl/murmur64a_byte_hash_core.sv =====
// streaming 64-bit murmur64a hash core with a fixed seed
// depends on mmh_pkg, mmh_mul and the assertion macro header
`include "murmur64a_byte_hash_core_macros.svh"

// Each item carries one little-endian 64-bit message word; the item marked first
// also carries the total length that seeds the hash, and the item marked last
// yields one hash_value (h ^ h >> 47, without the usual closing multiply). All
// 64-bit products go through one 32x32 multiplier that takes three steps per
// product. An item needs three products for a full word, one for a partial
// word of 1 to 7 bytes and none for zero bytes, plus one on the first item of
// a message for the seed product. s_ready is low while an item is being
// worked. A finished hash waits in an output register, so the next item is
// taken while it is pending; a last item finishing onto a still-full output
// register holds until it drains. An item without first outside a message is
// taken and dropped.
module murmur64a_byte_hash_core
    import mmh_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [WORD_W-1:0]   s_data_word,
    input  logic [COUNT_W-1:0]  s_byte_count,
    input  logic [LENGTH_W-1:0] s_message_length,
    input  logic                s_first,
    input  logic                s_last,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [WORD_W-1:0]   m_hash_value
);

    mmh_state_t          state_reg, state_next;
    logic [WORD_W-1:0]   h_reg, h_next;
    logic                in_message_reg, in_message_next;
    logic                m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]   m_hash_reg;

    logic [WORD_W-1:0]   word_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic                first_reg;
    logic                last_reg;

    mmh_mul_req_t        mul_req;
    mmh_mul_rsp_t        mul_rsp;

    logic                in_accept;
    logic                dispatch;
    logic [WORD_W-1:0]   disp_src;
    logic [WORD_W-1:0]   byte_mask;
    logic [WORD_W-1:0]   partial_x;
    logic                out_load;

    mmh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;

    // word handling starts once the running hash is known
    assign dispatch = ((state_reg == ST_LOAD) && !first_reg)
                   || ((state_reg == ST_SEED) && mul_rsp.done);
    assign disp_src = (state_reg == ST_SEED) ? (HASH_SEED ^ mul_rsp.product) : h_reg;

    // keep only the valid bytes of a partial word
    always_comb begin
        for (int i = 0; i < BYTES; i++) begin
            byte_mask[i*8 +: 8] = (COUNT_W'(i) < count_reg) ? 8'hff : 8'h00;
        end
    end
    assign partial_x = disp_src ^ (word_reg & byte_mask);

    assign out_load = (state_reg == ST_FINISH) && last_reg && (!m_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_first || in_message_reg)) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD, ST_SEED: begin
                if (state_reg == ST_LOAD && first_reg) begin
                    state_next = ST_SEED;
                end else if (dispatch) begin
                    if (count_reg[COUNT_W-1]) begin
                        state_next = ST_MIX1;
                    end else if (count_reg != '0) begin
                        state_next = ST_FOLD;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_MIX1: if (mul_rsp.done) state_next = ST_MIX2;
            ST_MIX2: if (mul_rsp.done) state_next = ST_FOLD;
            ST_FOLD: if (mul_rsp.done) state_next = ST_FINISH;
            ST_FINISH: begin
                if (!last_reg || out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // multiply requests and running hash updates
    always_comb begin
        mul_req.start   = 1'b0;
        mul_req.operand = h_reg;
        h_next          = h_reg;
        unique case (state_reg)
            ST_LOAD, ST_SEED: begin
                if (state_reg == ST_LOAD && first_reg) begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = {{(WORD_W-LENGTH_W){1'b0}}, length_reg};
                end else if (dispatch) begin
                    if (count_reg[COUNT_W-1]) begin
                        h_next          = disp_src;
                        mul_req.start   = 1'b1;
                        mul_req.operand = word_reg;
                    end else if (count_reg != '0) begin
                        h_next          = partial_x;
                        mul_req.start   = 1'b1;
                        mul_req.operand = partial_x;
                    end else begin
                        h_next          = disp_src;
                    end
                end
            end
            ST_MIX1: begin
                if (mul_rsp.done) begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = xor_shift(mul_rsp.product);
                end
            end
            ST_MIX2: begin
                if (mul_rsp.done) begin
                    h_next          = h_reg ^ mul_rsp.product;
                    mul_req.start   = 1'b1;
                    mul_req.operand = h_reg ^ mul_rsp.product;
                end
            end
            ST_FOLD: begin
                if (mul_rsp.done) begin
                    h_next = mul_rsp.product;
                end
            end
            default: begin
                h_next = h_reg;
            end
        endcase
    end

    // message tracking and output register
    always_comb begin
        in_message_next = in_message_reg;
        if (in_accept && s_first) begin
            in_message_next = 1'b1;
        end else if (out_load) begin
            in_message_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_message_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            in_message_reg <= in_message_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // item and hash payload registers
    always_ff @(posedge aclk) begin
        h_reg <= h_next;
        if (in_accept) begin
            word_reg   <= s_data_word;
            count_reg  <= s_byte_count;
            length_reg <= s_message_length;
            first_reg  <= s_first;
            last_reg   <= s_last;
        end
        if (out_load) begin
            m_hash_reg <= xor_shift(h_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

    `MMH_ASSERT_NEXT(a_first_opens, in_accept && s_first, in_message_reg,
        "first item did not open a message")
    `MMH_ASSERT_NOW(a_done_waited, mul_rsp.done,
        state_reg == ST_SEED || state_reg == ST_MIX1 || state_reg == ST_MIX2 || state_reg == ST_FOLD,
        "product returned outside a wait state")
    `MMH_ASSERT_NOW(a_out_from_last, $rose(m_valid_reg),
        $past(state_reg) == ST_FINISH && $past(last_reg),
        "hash presented without a finished last item")

endmodule
